### rtl/core/cau_pkg.sv
package cau_pkg;

    typedef enum logic [1:0] {
        K_ADD = 2'd0,
        K_SUB = 2'd1,
        K_MUL = 2'd2,
        K_DIV = 2'd3
    } t_kind;

    typedef struct packed {
        logic valid;
        logic is_div;
        logic dz;
        logic neg_r;
        logic neg_i;
        logic ovf_r;
        logic ovf_i;
    } t_ctl;

endpackage

### rtl/core/cau_if.sv
interface cau_in_if #(parameter int PART_WIDTH = 16);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   kind;
    logic signed [PART_WIDTH-1:0] a_real;
    logic signed [PART_WIDTH-1:0] a_imag;
    logic signed [PART_WIDTH-1:0] b_real;
    logic signed [PART_WIDTH-1:0] b_imag;

    modport source (output valid, kind, a_real, a_imag, b_real, b_imag, input ready);
    modport sink (input valid, kind, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if #(parameter int PART_WIDTH = 16);
    logic                         valid;
    logic                         ready;
    logic signed [PART_WIDTH-1:0] result_real;
    logic signed [PART_WIDTH-1:0] result_imag;
    logic                         saturated;
    logic                         divide_by_zero;

    modport source (output valid, result_real, result_imag, saturated, divide_by_zero,
                    input ready);
    modport sink (input valid, result_real, result_imag, saturated, divide_by_zero,
                  output ready);
endinterface

### rtl/core/cau_div_cell.sv
module cau_div_cell import cau_pkg::*; #(
    parameter int DW = 32,
    parameter int QW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  t_ctl          i_ctl,
    input  logic [DW-1:0] i_den,
    input  logic [DW-1:0] i_rem_r,
    input  logic [QW-1:0] i_nq_r,
    input  logic [DW-1:0] i_rem_i,
    input  logic [QW-1:0] i_nq_i,
    output t_ctl          o_ctl,
    output logic [DW-1:0] o_den,
    output logic [DW-1:0] o_rem_r,
    output logic [QW-1:0] o_nq_r,
    output logic [DW-1:0] o_rem_i,
    output logic [QW-1:0] o_nq_i
);

    t_ctl          r_ctl;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem_r;
    logic [QW-1:0] r_nq_r;
    logic [DW-1:0] r_rem_i;
    logic [QW-1:0] r_nq_i;

    logic [DW:0]   t_r;
    logic [DW:0]   t_i;
    logic          ge_r;
    logic          ge_i;
    logic [DW-1:0] n_rem_r;
    logic [DW-1:0] n_rem_i;

    // one restoring quotient bit per lane
    always_comb begin
        t_r     = {i_rem_r, i_nq_r[QW-1]};
        t_i     = {i_rem_i, i_nq_i[QW-1]};
        ge_r    = t_r >= {1'b0, i_den};
        ge_i    = t_i >= {1'b0, i_den};
        n_rem_r = ge_r ? DW'(t_r - {1'b0, i_den}) : t_r[DW-1:0];
        n_rem_i = ge_i ? DW'(t_i - {1'b0, i_den}) : t_i[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den   <= i_den;
            r_rem_r <= n_rem_r;
            r_rem_i <= n_rem_i;
            r_nq_r  <= {i_nq_r[QW-2:0], ge_r};
            r_nq_i  <= {i_nq_i[QW-2:0], ge_i};
        end
    end

    assign o_ctl   = r_ctl;
    assign o_den   = r_den;
    assign o_rem_r = r_rem_r;
    assign o_nq_r  = r_nq_r;
    assign o_rem_i = r_rem_i;
    assign o_nq_i  = r_nq_i;

endmodule

### rtl/core/complex_arithmetic_unit_top.sv
// Complex ALU on Q(PART_WIDTH-FRACTION_BITS-1).FRACTION_BITS parts: add, subtract,
// multiply (round half up) and divide (truncate toward zero), all saturated. One item
// is accepted every cycle while the output is not stalled; each result passes through
// PART_WIDTH+5 register stages: three front stages (products, sums and magnitudes,
// overflow check), a chain of PART_WIDTH+1 divider cells that each resolve one
// quotient bit, and the output register. A stalled output holds the whole pipeline.
module complex_arithmetic_unit_top import cau_pkg::*; #(
    parameter int PART_WIDTH    = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cau_in_if.sink     i_in,
    cau_out_if.source  o_out
);

    localparam int W  = PART_WIDTH;
    localparam int F  = FRACTION_BITS;
    localparam int PW = 2 * W;
    localparam int RW = 2 * W + 1;
    localparam int DW = 2 * W;
    localparam int QW = W + 1;
    localparam int NW = 2 * W + 1 + F;
    localparam int XW = 3 * W + F + 2;

    localparam logic signed [RW-1:0] HALF = RW'((2 ** F) / 2);
    localparam logic signed [RW-1:0] SATV = RW'(1) << W;
    localparam logic signed [RW-1:0] MAXV = (RW'(1) << (W - 1)) - RW'(1);
    localparam logic signed [RW-1:0] MINV = -(RW'(1) << (W - 1));

    logic en;

    logic                 r1_valid;
    t_kind                r1_kind;
    logic signed [PW-1:0] r1_ac, r1_bd, r1_ad, r1_bc, r1_cc, r1_dd;
    logic signed [RW-1:0] r1_sum_r, r1_sum_i;

    logic signed [RW-1:0] n_nr, n_ni, n_mr, n_mi;
    logic [DW-1:0]        n_den;

    t_ctl                 r2_ctl;
    logic signed [RW-1:0] r2_res_r, r2_res_i;
    logic [NW-1:0]        r2_mag_r, r2_mag_i;
    logic [DW-1:0]        r2_den;

    t_ctl                 c_ctl   [0:QW];
    logic [DW-1:0]        c_den   [0:QW];
    logic [DW-1:0]        c_rem_r [0:QW];
    logic [QW-1:0]        c_nq_r  [0:QW];
    logic [DW-1:0]        c_rem_i [0:QW];
    logic [QW-1:0]        c_nq_i  [0:QW];
    logic signed [RW-1:0] r_sr    [0:QW];
    logic signed [RW-1:0] r_si    [0:QW];

    t_ctl                 n3_ctl;

    logic signed [RW-1:0] v_r, v_i;
    logic                 sat_r, sat_i;
    logic signed [W-1:0]  n_out_r, n_out_i;

    logic                 r_out_valid;
    logic signed [W-1:0]  r_out_r, r_out_i;
    logic                 r_out_sat, r_out_dz;

    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    // products and add/sub
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_kind <= t_kind'(i_in.kind);
            r1_ac   <= i_in.a_real * i_in.b_real;
            r1_bd   <= i_in.a_imag * i_in.b_imag;
            r1_ad   <= i_in.a_real * i_in.b_imag;
            r1_bc   <= i_in.a_imag * i_in.b_real;
            r1_cc   <= i_in.b_real * i_in.b_real;
            r1_dd   <= i_in.b_imag * i_in.b_imag;
            if (t_kind'(i_in.kind) == K_SUB) begin
                r1_sum_r <= RW'(i_in.a_real) - RW'(i_in.b_real);
                r1_sum_i <= RW'(i_in.a_imag) - RW'(i_in.b_imag);
            end else begin
                r1_sum_r <= RW'(i_in.a_real) + RW'(i_in.b_real);
                r1_sum_i <= RW'(i_in.a_imag) + RW'(i_in.b_imag);
            end
        end
    end

    // sums, rounding, magnitudes
    always_comb begin
        n_nr  = RW'(r1_ac) + RW'(r1_bd);
        n_ni  = RW'(r1_bc) - RW'(r1_ad);
        n_mr  = (RW'(r1_ac) - RW'(r1_bd) + HALF) >>> F;
        n_mi  = (RW'(r1_ad) + RW'(r1_bc) + HALF) >>> F;
        n_den = DW'($unsigned(r1_cc)) + DW'($unsigned(r1_dd));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else if (en) begin
            r2_ctl.valid  <= r1_valid;
            r2_ctl.is_div <= r1_kind == K_DIV;
            r2_ctl.dz     <= (r1_kind == K_DIV) && (n_den == '0);
            r2_ctl.neg_r  <= n_nr < 0;
            r2_ctl.neg_i  <= n_ni < 0;
            r2_ctl.ovf_r  <= 1'b0;
            r2_ctl.ovf_i  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_res_r <= (r1_kind == K_MUL) ? n_mr : r1_sum_r;
            r2_res_i <= (r1_kind == K_MUL) ? n_mi : r1_sum_i;
            r2_mag_r <= NW'($unsigned((n_nr < 0) ? -n_nr : n_nr)) << F;
            r2_mag_i <= NW'($unsigned((n_ni < 0) ? -n_ni : n_ni)) << F;
            r2_den   <= n_den;
        end
    end

    // quotient overflow check and divider setup
    always_comb begin
        n3_ctl       = r2_ctl;
        n3_ctl.ovf_r = XW'(r2_mag_r) >= (XW'(r2_den) << QW);
        n3_ctl.ovf_i = XW'(r2_mag_i) >= (XW'(r2_den) << QW);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            c_ctl[0] <= '0;
        end else if (en) begin
            c_ctl[0] <= n3_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            c_den[0]   <= r2_den;
            c_rem_r[0] <= DW'(r2_mag_r >> QW);
            c_nq_r[0]  <= r2_mag_r[QW-1:0];
            c_rem_i[0] <= DW'(r2_mag_i >> QW);
            c_nq_i[0]  <= r2_mag_i[QW-1:0];
            r_sr[0]    <= r2_res_r;
            r_si[0]    <= r2_res_i;
        end
    end

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_cell
            cau_div_cell #(
                .DW (DW),
                .QW (QW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_ctl   (c_ctl[k]),
                .i_den   (c_den[k]),
                .i_rem_r (c_rem_r[k]),
                .i_nq_r  (c_nq_r[k]),
                .i_rem_i (c_rem_i[k]),
                .i_nq_i  (c_nq_i[k]),
                .o_ctl   (c_ctl[k+1]),
                .o_den   (c_den[k+1]),
                .o_rem_r (c_rem_r[k+1]),
                .o_nq_r  (c_nq_r[k+1]),
                .o_rem_i (c_rem_i[k+1]),
                .o_nq_i  (c_nq_i[k+1])
            );

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_sr[k+1] <= r_sr[k];
                    r_si[k+1] <= r_si[k];
                end
            end
        end
    endgenerate

    // result select and saturation
    always_comb begin
        if (!c_ctl[QW].is_div) begin
            v_r = r_sr[QW];
            v_i = r_si[QW];
        end else begin
            if (c_ctl[QW].ovf_r) begin
                v_r = c_ctl[QW].neg_r ? -SATV : SATV;
            end else begin
                v_r = c_ctl[QW].neg_r ? -RW'(c_nq_r[QW]) : RW'(c_nq_r[QW]);
            end
            if (c_ctl[QW].ovf_i) begin
                v_i = c_ctl[QW].neg_i ? -SATV : SATV;
            end else begin
                v_i = c_ctl[QW].neg_i ? -RW'(c_nq_i[QW]) : RW'(c_nq_i[QW]);
            end
        end
        sat_r   = (v_r > MAXV) || (v_r < MINV);
        sat_i   = (v_i > MAXV) || (v_i < MINV);
        n_out_r = (v_r > MAXV) ? MAXV[W-1:0] : ((v_r < MINV) ? MINV[W-1:0] : v_r[W-1:0]);
        n_out_i = (v_i > MAXV) ? MAXV[W-1:0] : ((v_i < MINV) ? MINV[W-1:0] : v_i[W-1:0]);
        if (c_ctl[QW].dz) begin
            sat_r   = 1'b0;
            sat_i   = 1'b0;
            n_out_r = '0;
            n_out_i = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= c_ctl[QW].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_r   <= n_out_r;
            r_out_i   <= n_out_i;
            r_out_sat <= sat_r || sat_i;
            r_out_dz  <= c_ctl[QW].dz;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.result_real    = r_out_r;
    assign o_out.result_imag    = r_out_i;
    assign o_out.saturated      = r_out_sat;
    assign o_out.divide_by_zero = r_out_dz;

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_dz |-> r_out_r == '0 && r_out_i == '0 && !r_out_sat)
        else $error("zero divisor result not cleared");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_out_r) && $stable(r_out_i))
        else $error("stalled item lost");

    a_dz_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_ctl[QW].dz |-> c_ctl[QW].is_div)
        else $error("zero divisor flag on non-divide item");

endmodule
